// ===== design/stx_etx_frame_builder_lrc_sum_top_macros.svh =====
// assertion helpers for the checker file
`ifndef STX_ETX_FRAME_BUILDER_LRC_SUM_TOP_MACROS_SVH
`define STX_ETX_FRAME_BUILDER_LRC_SUM_TOP_MACROS_SVH

// plain property under clk, off while in reset
`define SEFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication under clk, off while in reset
`define SEFB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/sefb_pkg.sv =====
`timescale 1ns / 1ps
package sefb_pkg;

	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;

	// output phases of one queued command
	localparam logic [2:0] PH_STX    = 3'd0;
	localparam logic [2:0] PH_LEN_LO = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_PAY    = 3'd3;
	localparam logic [2:0] PH_LRC    = 3'd4;
	localparam logic [2:0] PH_SUM    = 3'd5;
	localparam logic [2:0] PH_ETX    = 3'd6;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [15:0] frame_len;
		logic        empty_frame;
	} pay_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frm_item_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic        hdr;
		logic        pay;
		logic        trl;
		logic [7:0]  data;
		logic [15:0] len;
		logic [7:0]  lrc;
		logic [7:0]  sum;
	} sefb_cmd_t;

endpackage

// ===== design/sefb_front.sv =====
`timescale 1ns / 1ps
module sefb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pay_valid,
	input  sefb_pkg::pay_item_t pay_data,
	input  logic                q_full,
	output logic                q_push,
	output sefb_pkg::sefb_cmd_t q_cmd
);
	import sefb_pkg::*;

	logic        in_frame_q;
	logic [15:0] bytes_left_q;
	logic [7:0]  lrc_q;
	logic [7:0]  sum_q;

	logic        is_empty;
	logic        is_start;
	logic [15:0] left_now;
	logic [15:0] left_next;
	logic [7:0]  lrc_next;
	logic [7:0]  sum_next;
	logic        is_last;

	assign q_push = pay_valid && !q_full;

	// classify the incoming byte against the open frame
	always_comb begin
		is_empty  = pay_data.empty_frame || (!in_frame_q && pay_data.frame_len == 16'd0);
		is_start  = !in_frame_q;
		left_now  = is_start ? pay_data.frame_len : bytes_left_q;
		left_next = left_now - 16'd1;
		lrc_next  = (is_start ? 8'd0 : lrc_q) ^ pay_data.payload_byte;
		sum_next  = (is_start ? 8'd0 : sum_q) + pay_data.payload_byte;
		is_last   = (left_next == 16'd0);
	end

	// command for the back end; an empty frame is a header and a zero trailer
	always_comb begin
		if (is_empty) begin
			q_cmd.hdr  = 1'b1;
			q_cmd.pay  = 1'b0;
			q_cmd.trl  = 1'b1;
			q_cmd.data = 8'd0;
			q_cmd.len  = 16'd0;
			q_cmd.lrc  = 8'd0;
			q_cmd.sum  = 8'd0;
		end else begin
			q_cmd.hdr  = is_start;
			q_cmd.pay  = 1'b1;
			q_cmd.trl  = is_last;
			q_cmd.data = pay_data.payload_byte;
			q_cmd.len  = pay_data.frame_len;
			q_cmd.lrc  = lrc_next;
			q_cmd.sum  = sum_next;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= 16'd0;
			lrc_q        <= 8'd0;
			sum_q        <= 8'd0;
		end else if (q_push) begin
			if (is_empty || is_last) begin
				in_frame_q   <= 1'b0;
				bytes_left_q <= 16'd0;
				lrc_q        <= 8'd0;
				sum_q        <= 8'd0;
			end else begin
				in_frame_q   <= 1'b1;
				bytes_left_q <= left_next;
				lrc_q        <= lrc_next;
				sum_q        <= sum_next;
			end
		end
	end

endmodule

// ===== design/sefb_queue.sv =====
`timescale 1ns / 1ps
module sefb_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sefb_pkg::sefb_cmd_t push_cmd,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output sefb_pkg::sefb_cmd_t head_cmd
);
	import sefb_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sefb_cmd_t          slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/sefb_back.sv =====
`timescale 1ns / 1ps
module sefb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  sefb_pkg::sefb_cmd_t head_cmd,
	output logic                pop,
	output logic                frm_valid,
	input  logic                frm_stall,
	output sefb_pkg::frm_item_t frm_data
);
	import sefb_pkg::*;

	logic       busy_q;
	logic [2:0] phase_q;
	logic       out_valid_q;
	frm_item_t  out_q;

	logic       load;
	logic [2:0] first_ph;
	logic [2:0] last_ph;
	logic [2:0] cur_ph;
	logic [2:0] next_ph;
	frm_item_t  cur_item;

	assign frm_valid = out_valid_q;
	assign frm_data  = out_q;

	// output register takes a byte when empty or being drained
	assign load = head_valid && (!out_valid_q || !frm_stall);
	assign pop  = load && (cur_ph == last_ph);

	// phase walk for the head command
	always_comb begin
		if (head_cmd.hdr) begin
			first_ph = PH_STX;
		end else if (head_cmd.pay) begin
			first_ph = PH_PAY;
		end else begin
			first_ph = PH_LRC;
		end
		last_ph = head_cmd.trl ? PH_ETX : PH_PAY;
		cur_ph  = busy_q ? phase_q : first_ph;
		if (cur_ph == PH_LEN_HI && !head_cmd.pay) begin
			next_ph = PH_LRC;
		end else begin
			next_ph = cur_ph + 3'd1;
		end
	end

	// byte for the current phase
	always_comb begin
		cur_item.frame_end = 1'b0;
		case (cur_ph)
			PH_STX:    cur_item.frame_byte = STX_BYTE;
			PH_LEN_LO: cur_item.frame_byte = head_cmd.len[7:0];
			PH_LEN_HI: cur_item.frame_byte = head_cmd.len[15:8];
			PH_PAY:    cur_item.frame_byte = head_cmd.data;
			PH_LRC:    cur_item.frame_byte = head_cmd.lrc;
			PH_SUM:    cur_item.frame_byte = head_cmd.sum;
			PH_ETX: begin
				cur_item.frame_byte = ETX_BYTE;
				cur_item.frame_end  = 1'b1;
			end
			default:   cur_item.frame_byte = 8'd0;
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_STX;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= !pop;
				phase_q <= next_ph;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!frm_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= cur_item;
		end
	end

endmodule

// ===== design/stx_etx_frame_builder_lrc_sum_top.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// pay      in   pay_valid/pay_stall  pay_data (payload_byte, frame_len, empty_frame)
// frm      out  frm_valid/frm_stall  frm_data (frame_byte, frame_end)
//
// a mid-frame payload byte becomes one frame byte; the first byte of a frame adds
// the STX/length header, the last the LRC/SUM/ETX trailer; an empty frame is both;
// the back end emits one frame byte per unstalled cycle into its output register.
// the front accepts one byte per cycle until the command queue is full.
// reset clears frame state, queue and output valid; no clearing pass.
// a stalled output holds its byte; input stalls only on a full queue.
module stx_etx_frame_builder_lrc_sum_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pay_valid,
	output logic                pay_stall,
	input  sefb_pkg::pay_item_t pay_data,
	output logic                frm_valid,
	input  logic                frm_stall,
	output sefb_pkg::frm_item_t frm_data
);
	import sefb_pkg::*;

	logic      q_full;
	logic      q_push;
	sefb_cmd_t q_cmd;
	logic      q_pop;
	logic      head_valid;
	sefb_cmd_t head_cmd;

	assign pay_stall = q_full;

	sefb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pay_valid(pay_valid),
		.pay_data (pay_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	sefb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	sefb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (q_pop),
		.frm_valid (frm_valid),
		.frm_stall (frm_stall),
		.frm_data  (frm_data)
	);

endmodule

// ===== design/sefb_checker.sv =====
`timescale 1ns / 1ps
`include "stx_etx_frame_builder_lrc_sum_top_macros.svh"
module sefb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pay_valid,
	input logic                pay_stall,
	input logic                frm_valid,
	input logic                frm_stall,
	input sefb_pkg::frm_item_t frm_data
);
	import sefb_pkg::*;

	// a stalled output transaction holds
	`SEFB_ASSERT_IMP(a_frm_hold, frm_valid && frm_stall, ##1 (frm_valid && $stable(frm_data)), "frm transaction changed under stall")

	// frame end only on the closing byte
	`SEFB_ASSERT_IMP(a_end_is_etx, frm_valid && frm_data.frame_end, frm_data.frame_byte == ETX_BYTE, "frame end on a byte other than ETX")

	// an accepted input shows output once it has passed the queue and the output register
	`SEFB_ASSERT_IMP(a_out_follows, pay_valid && !pay_stall, ##2 frm_valid, "no output after accepted input")

endmodule

bind stx_etx_frame_builder_lrc_sum_top sefb_checker u_sefb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pay_valid(pay_valid),
	.pay_stall(pay_stall),
	.frm_valid(frm_valid),
	.frm_stall(frm_stall),
	.frm_data (frm_data)
);
